### hw/rtl/spq_pkg.sv
// Shared types, constants and codes for the sorted priority queue.
package spq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 8;

  localparam int KEY_FIELD_BITS  = 8;
  localparam int PAYLOAD_BITS    = 31;
  localparam int OCC_BITS        = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_INS_CMP,
    ST_INS_HEAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                       operation;
    logic [KEY_FIELD_BITS-1:0] key_in;
    logic [PAYLOAD_BITS-1:0]   payload_in;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [KEY_FIELD_BITS-1:0] key_out;
    logic [PAYLOAD_BITS-1:0]   payload_out;
    logic [OCC_BITS-1:0]       occupancy;
  } rsp_t;

endpackage

### hw/rtl/spq_mem.sv
// Entry storage: key and payload arrays with one write port and one registered read port.
module spq_mem
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int KW          = DEF_KEY_BITS
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  logic [KW-1:0]                  wr_key,
  input  logic [PAYLOAD_BITS-1:0]        wr_payload,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output logic [KW-1:0]                  rd_key,
  output logic [PAYLOAD_BITS-1:0]        rd_payload
);

  logic [KW-1:0]           key_mem     [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]     <= wr_key;
      payload_mem[wr_addr] <= wr_payload;
    end
  end

  always_ff @(posedge clk) begin
    rd_key     <= key_mem[rd_addr];
    rd_payload <= payload_mem[rd_addr];
  end

endmodule

### hw/rtl/spq_ctrl.sv
// Queue sequencer: circular head pointer, tail-to-front insertion walk and result capture.
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int KW          = DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  req_t                             req,
  output logic                             res_valid,
  input  logic                             res_ready,
  output status_t                          res_status,
  output logic [KW-1:0]                    res_key,
  output logic [PAYLOAD_BITS-1:0]          res_payload,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] res_occ,
  output logic                             mem_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_waddr,
  output logic [KW-1:0]                    mem_wkey,
  output logic [PAYLOAD_BITS-1:0]          mem_wpayload,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_raddr,
  input  logic [KW-1:0]                    mem_rkey,
  input  logic [PAYLOAD_BITS-1:0]          mem_rpayload
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_SUM  = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(QUEUE_DEPTH - 1);

  state_t                  state, state_next;
  logic [KW-1:0]           key;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [AW-1:0]           head;
  logic [CW-1:0]           count;
  logic [AW-1:0]           idx;

  logic                    accept;
  logic                    is_empty;
  logic                    is_full;
  logic [AW-1:0]           count_m1;
  logic [AW-1:0]           head_inc;
  logic                    stop_here;

  // Logical position to physical slot, relative to the head of the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[AW-1:0];
  endfunction

  assign accept    = req_valid && req_ready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == DEPTH_CNT);
  assign count_m1  = AW'(count - 1'b1);
  assign head_inc  = (head == LAST_SLOT) ? '0 : AW'(head + 1'b1);
  // The walk stops once it meets an entry with a strictly greater key.
  assign stop_here = (mem_rkey > key);

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.operation == OP_POP) begin
            state_next = is_empty ? ST_DONE : ST_POP_RD;
          end else if (is_full || is_empty) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_INS_CMP;
          end
        end
      end
      ST_POP_RD:   state_next = ST_DONE;
      ST_INS_CMP: begin
        if (stop_here) begin
          state_next = ST_DONE;
        end else if (idx == '0) begin
          state_next = ST_INS_HEAD;
        end
      end
      ST_INS_HEAD: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = head;
    mem_wkey     = key;
    mem_wpayload = payload;
    mem_raddr    = head;
    unique case (state)
      ST_IDLE: begin
        mem_raddr = (req.operation == OP_POP) ? head : phys(head, count_m1);
        // First entry into an empty queue goes straight to the head slot.
        if (accept && req.operation == OP_INSERT && is_empty) begin
          mem_we       = 1'b1;
          mem_wkey     = KW'(req.key_in);
          mem_wpayload = req.payload_in;
        end
      end
      ST_INS_CMP: begin
        mem_raddr = phys(head, AW'(idx - 1'b1));
        mem_we    = 1'b1;
        mem_waddr = phys(head, AW'(idx + 1'b1));
        if (!stop_here) begin
          mem_wkey     = mem_rkey;
          mem_wpayload = mem_rpayload;
        end
      end
      ST_INS_HEAD: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept && req.operation == OP_INSERT && is_empty) begin
            count <= CW'(1);
          end
        end
        ST_POP_RD: begin
          head  <= head_inc;
          count <= count - 1'b1;
        end
        ST_INS_CMP: begin
          if (stop_here) begin
            count <= count + 1'b1;
          end
        end
        ST_INS_HEAD: begin
          count <= count + 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          key         <= KW'(req.key_in);
          payload     <= req.payload_in;
          idx         <= count_m1;
          res_key     <= '0;
          res_payload <= '0;
          if (req.operation == OP_POP && is_empty) begin
            res_status <= STATUS_EMPTY;
          end else if (req.operation == OP_INSERT && is_full) begin
            res_status <= STATUS_FULL;
          end else begin
            res_status <= STATUS_OK;
          end
          res_occ <= (req.operation == OP_INSERT && is_empty) ? CW'(1) : count;
        end
      end
      ST_POP_RD: begin
        res_key     <= mem_rkey;
        res_payload <= mem_rpayload;
        res_occ     <= count - 1'b1;
      end
      ST_INS_CMP: begin
        if (stop_here) begin
          res_occ <= count + 1'b1;
        end else if (idx != '0) begin
          idx <= AW'(idx - 1'b1);
        end
      end
      ST_INS_HEAD: begin
        res_occ <= count + 1'b1;
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

### hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: storage, sequencer and output register.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_ready  req  (operation, key_in, payload_in)
//   rsp      out  rsp_valid / rsp_ready  rsp  (status, key_out, payload_out, occupancy)
//
// One transaction is in progress at a time. A pop reads the head entry, then its result
// is ready; an insert into an empty or full queue and a pop on empty go straight to the
// result; any other insert walks past each stored entry whose key is not greater than the
// new key. The single read port walking from the tail toward the head sets the insert
// time. Reset empties the queue at once. A held result does not block the next request.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;

  logic                    res_valid;
  logic                    res_ready;
  status_t                 res_status;
  logic [KW-1:0]           res_key;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [CW-1:0]           res_occ;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [KW-1:0]           mem_wkey;
  logic [PAYLOAD_BITS-1:0] mem_wpayload;
  logic [AW-1:0]           mem_raddr;
  logic [KW-1:0]           mem_rkey;
  logic [PAYLOAD_BITS-1:0] mem_rpayload;

  spq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KW          (KW)
  ) u_mem (
    .clk        (clk),
    .wr_en      (mem_we),
    .wr_addr    (mem_waddr),
    .wr_key     (mem_wkey),
    .wr_payload (mem_wpayload),
    .rd_addr    (mem_raddr),
    .rd_key     (mem_rkey),
    .rd_payload (mem_rpayload)
  );

  spq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KW          (KW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_status   (res_status),
    .res_key      (res_key),
    .res_payload  (res_payload),
    .res_occ      (res_occ),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wkey     (mem_wkey),
    .mem_wpayload (mem_wpayload),
    .mem_raddr    (mem_raddr),
    .mem_rkey     (mem_rkey),
    .mem_rpayload (mem_rpayload)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.status      <= res_status;
      rsp.key_out     <= KEY_FIELD_BITS'(res_key);
      rsp.payload_out <= res_payload;
      rsp.occupancy   <= OCC_BITS'(res_occ);
    end
  end

endmodule

### dv/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue: a directed table, then paced random traffic.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int KEY_BITS = DEF_KEY_BITS;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_MASK = KEY_FIELD_BITS'((64'd1 << KEY_BITS) - 1);
  localparam int RANDOM_OPS = 1800;
  localparam int PHASES = 4;
  localparam int BURST_LEN = 24;
  // Slowest transaction is an insert that walks past every stored entry.
  localparam int SETTLE_CYCLES = 3 + QUEUE_DEPTH + 8;

  typedef enum int {
    KEYS_ANY,
    KEYS_FEW,
    KEYS_EDGE,
    KEYS_BAND
  } key_mix_t;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b1;
  rsp_t rsp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int insert_count = 0;
  int pop_count = 0;
  int dropped_count = 0;
  int empty_pop_count = 0;

  // Shadow copy of the queue contents, front entry at index 0.
  logic [KEY_FIELD_BITS-1:0] shadow_key [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]   shadow_pay [QUEUE_DEPTH];
  int shadow_count = 0;

  rsp_t rsp_due [$];
  stim_row_t stim_table [$];

  sorted_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Applies one operation to the shadow queue and returns the response it should produce.
  function automatic rsp_t apply_to_shadow(req_t item);
    rsp_t r;
    int pos;
    logic [KEY_FIELD_BITS-1:0] k;
    r = '0;
    r.status = STATUS_OK;
    k = item.key_in & KEY_MASK;
    if (item.operation == OP_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // New entry goes ahead of every entry whose key is not greater.
        pos = 0;
        while (pos < shadow_count && shadow_key[pos] > k) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_key[i] = shadow_key[i-1];
          shadow_pay[i] = shadow_pay[i-1];
        end
        shadow_key[pos] = k;
        shadow_pay[pos] = item.payload_in;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.key_out = shadow_key[0];
        r.payload_out = shadow_pay[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_key[i-1] = shadow_key[i];
          shadow_pay[i-1] = shadow_pay[i];
        end
        shadow_count--;
      end
    end
    r.occupancy = OCC_BITS'(shadow_count);
    return r;
  endfunction

  function automatic void add_row(op_t op, logic [KEY_FIELD_BITS-1:0] k,
                                  logic [PAYLOAD_BITS-1:0] p, bit typed, status_t st,
                                  logic [KEY_FIELD_BITS-1:0] ko,
                                  logic [PAYLOAD_BITS-1:0] po, logic [OCC_BITS-1:0] occ);
    stim_row_t row;
    row.item.operation = op;
    row.item.key_in = k;
    row.item.payload_in = p;
    row.typed = typed;
    row.want.status = st;
    row.want.key_out = ko;
    row.want.payload_out = po;
    row.want.occupancy = occ;
    stim_table.push_back(row);
  endfunction

  function automatic req_t random_op(int insert_pct, key_mix_t mix);
    req_t item;
    item.operation = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
    case (mix)
      KEYS_FEW:  item.key_in = KEY_FIELD_BITS'($urandom_range(0, 3));
      KEYS_EDGE: begin
        case ($urandom_range(0, 3))
          0:       item.key_in = '0;
          1:       item.key_in = 8'h01;
          2:       item.key_in = 8'hFE;
          default: item.key_in = '1;
        endcase
      end
      KEYS_BAND: item.key_in = KEY_FIELD_BITS'($urandom_range(100, 107));
      default:   item.key_in = KEY_FIELD_BITS'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0:       item.payload_in = '0;
      1:       item.payload_in = '1;
      default: item.payload_in = PAYLOAD_BITS'($urandom);
    endcase
    return item;
  endfunction

  // Presents one transaction and records its expected response once accepted.
  task automatic send_op(req_t item, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = apply_to_shadow(item);
    rsp_due.push_back(typed ? typed_rsp : predicted);
    case (predicted.status)
      STATUS_FULL:  dropped_count++;
      STATUS_EMPTY: empty_pop_count++;
      default: ;
    endcase
    if (item.operation == OP_INSERT) insert_count++;
    else pop_count++;
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_due.size() == 0) begin
        $error("response with no transaction outstanding: %p", rsp);
        fail_count++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          fail_count++;
        end
        if (rsp.key_out !== want.key_out) begin
          $error("key_out: expected %0d, actual %0d", want.key_out, rsp.key_out);
          fail_count++;
        end
        if (rsp.payload_out !== want.payload_out) begin
          $error("payload_out: expected 0x%08h, actual 0x%08h", want.payload_out,
                 rsp.payload_out);
          fail_count++;
        end
        if (rsp.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp.occupancy);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int phase_send [PHASES];
    int phase_recv [PHASES];
    int insert_pct;
    key_mix_t mix;
    phase_send = '{0, 76, 0, 15};
    phase_recv = '{0, 0, 76, 15};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(OP_POP, '0, '0, 1'b1, STATUS_EMPTY, '0, '0, 5'd0);
    add_row(OP_INSERT, 8'h00, '0, 1'b1, STATUS_OK, '0, '0, 5'd1);
    add_row(OP_INSERT, 8'hFF, '1, 1'b1, STATUS_OK, '0, '0, 5'd2);
    add_row(OP_POP, '0, '0, 1'b1, STATUS_OK, 8'hFF, '1, 5'd1);
    // A pop ignores whatever sits in the key and payload fields.
    add_row(OP_POP, 8'hFF, '1, 1'b1, STATUS_OK, 8'h00, '0, 5'd0);
    add_row(OP_POP, 8'hAA, 31'h2AAA_AAAA, 1'b1, STATUS_EMPTY, '0, '0, 5'd0);
    // Equal keys: the newest one must come out first.
    add_row(OP_INSERT, 8'd5, 31'd1, 1'b0, STATUS_OK, '0, '0, 5'd0);
    add_row(OP_INSERT, 8'd5, 31'd2, 1'b0, STATUS_OK, '0, '0, 5'd0);
    add_row(OP_INSERT, 8'd9, 31'd3, 1'b0, STATUS_OK, '0, '0, 5'd0);
    add_row(OP_INSERT, 8'd5, 31'd4, 1'b0, STATUS_OK, '0, '0, 5'd0);
    add_row(OP_POP, '0, '0, 1'b0, STATUS_OK, '0, '0, 5'd0);
    for (int i = 0; i < 13; i++) begin
      add_row(OP_INSERT, 8'((i * 73 + 11) & 8'hFF), 31'(32'h1357_9BDF * (i + 1)), 1'b0,
              STATUS_OK, '0, '0, 5'd0);
    end
    add_row(OP_INSERT, 8'h80, 31'h5555_5555, 1'b1, STATUS_FULL, '0, '0, 5'd16);

    foreach (stim_table[i]) send_op(stim_table[i].item, stim_table[i].typed,
                                    stim_table[i].want);
    drain_responses();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      insert_pct = 50;
      mix = KEYS_ANY;
      for (int n = 0; n < RANDOM_OPS / PHASES; n++) begin
        // Bursts with a skewed insert rate drive the queue to full and back to empty.
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(0, 3))
            0:       insert_pct = 20;
            1:       insert_pct = 50;
            2:       insert_pct = 80;
            default: insert_pct = 95;
          endcase
          mix = key_mix_t'($urandom_range(0, 3));
        end
        send_op(random_op(insert_pct, mix), 1'b0, '0);
      end
      // Let the queue answer everything before the pacing changes.
      drain_responses();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d inserts (%0d dropped while full) and %0d pops (%0d on an empty queue),",
             insert_count, dropped_count, pop_count, empty_pop_count);
    $display("under free-running, sender-idle, receiver-stall and mixed handshake pacing.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
